[rtl/matrix_inverse_3x3_defines.svh]
// ----------------------------------------------------------------------------
// matrix_inverse_3x3 assertion macros
// Concurrent assertion helpers used by the matrix_inverse_3x3 top module.
// ----------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_3X3_DEFINES_SVH
`define MATRIX_INVERSE_3X3_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MI3_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("matrix_inverse_3x3: implication check failed");
`define MI3_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("matrix_inverse_3x3: invariant check failed");
`else
`define MI3_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MI3_ASSERT_ALWAYS(label, clk, rst, cond)
`endif
`endif

[rtl/mi3_pkg.sv]
// ----------------------------------------------------------------------------
// mi3_pkg
// Types, widths and the cofactor selection table of the 3x3 matrix inverse.
// ----------------------------------------------------------------------------
package mi3_pkg;

   localparam int WORD_BITS     = 32;
   localparam int FRAC_BITS_DEF = 16;

   localparam int PROD_W = 2 * WORD_BITS;
   localparam int COF_W  = PROD_W + 1;
   localparam int PART_W = 2 * WORD_BITS + 1;
   localparam int TERM_W = 3 * WORD_BITS + 1;
   localparam int DET_W  = 3 * WORD_BITS + 3;
   localparam int REM_W  = DET_W + WORD_BITS;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [COF_W-1:0]     cof_type;

   typedef struct packed {
      word_type a00;
      word_type a01;
      word_type a02;
      word_type a10;
      word_type a11;
      word_type a12;
      word_type a20;
      word_type a21;
      word_type a22;
   } req_type;

   typedef struct packed {
      word_type r00;
      word_type r01;
      word_type r02;
      word_type r10;
      word_type r11;
      word_type r12;
      word_type r20;
      word_type r21;
      word_type r22;
      logic     singular;
      logic     saturated;
   } rsp_type;

   typedef struct packed {
      logic             zero;
      logic             neg;
      logic [DET_W-1:0] mag;
   } det_type;

   // Cofactor k is m[sel0]*m[sel1] - m[sel2]*m[sel3], elements in row-major order.
   localparam logic [3:0] COF_SEL [9][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7},
      '{4'd5, 4'd6, 4'd3, 4'd8},
      '{4'd3, 4'd7, 4'd4, 4'd6},
      '{4'd2, 4'd7, 4'd1, 4'd8},
      '{4'd0, 4'd8, 4'd2, 4'd6},
      '{4'd1, 4'd6, 4'd0, 4'd7},
      '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd0, 4'd4, 4'd1, 4'd3}
   };

endpackage

[rtl/matrix_inverse_3x3.sv]
// Throughput: one matrix per cycle outside reset; the quotient pipeline spends one
// stage on each of the WORD_BITS quotient bits, which is most of the latency.
// The receiver cannot stall: each result word is on the ports for one cycle.
// Reset clears all valid bits; busy is high only while reset is asserted.
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Fixed-point 3x3 inverse by the adjugate over the determinant, with singular
// detection and saturation of out-of-range elements.
// ----------------------------------------------------------------------------
`include "matrix_inverse_3x3_defines.svh"

module matrix_inverse_3x3
   import mi3_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic     accept;
   logic     cof_vld;
   cof_type  cof [9];
   word_type row0 [3];
   logic     det_vld;
   cof_type  cof_d [9];
   det_type  det_info;
   logic     [8:0] lane_vld;
   word_type lane_quo [9];
   logic     [8:0] lane_sat;
   logic     [8:0] lane_zero;

   assign busy   = reset;
   assign accept = start & ~busy;

   mi3_cof u_cof (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (req_data),
      .out_valid (cof_vld),
      .cof       (cof),
      .row0      (row0)
   );

   mi3_det u_det (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cof_vld),
      .cof_in    (cof),
      .row0      (row0),
      .out_valid (det_vld),
      .cof_out   (cof_d),
      .det       (det_info)
   );

   // Lane 3r+k takes cofactor 3k+r, which transposes the cofactor matrix.
   for (genvar i = 0; i < 9; i++) begin : g_lane
      mi3_div #(
         .FRAC_BITS (FRAC_BITS)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (det_vld),
         .cof_in    (cof_d[3*(i%3) + i/3]),
         .det_in    (det_info),
         .out_valid (lane_vld[i]),
         .quo       (lane_quo[i]),
         .sat       (lane_sat[i]),
         .zero      (lane_zero[i])
      );
   end

   assign rsp_valid          = lane_vld[0];
   assign rsp_data.r00       = lane_quo[0];
   assign rsp_data.r01       = lane_quo[1];
   assign rsp_data.r02       = lane_quo[2];
   assign rsp_data.r10       = lane_quo[3];
   assign rsp_data.r11       = lane_quo[4];
   assign rsp_data.r12       = lane_quo[5];
   assign rsp_data.r20       = lane_quo[6];
   assign rsp_data.r21       = lane_quo[7];
   assign rsp_data.r22       = lane_quo[8];
   assign rsp_data.singular  = lane_zero[0];
   assign rsp_data.saturated = |lane_sat;

   `MI3_ASSERT_ALWAYS(a_lanes_aligned, clock, reset, lane_vld == '0 || lane_vld == '1)
   `MI3_ASSERT_IMPL(a_singular_no_sat, clock, reset, rsp_valid && rsp_data.singular, !rsp_data.saturated)
   `MI3_ASSERT_IMPL(a_singular_zero, clock, reset, rsp_valid && rsp_data.singular, rsp_data.r00 == '0 && rsp_data.r11 == '0 && rsp_data.r22 == '0)

endmodule

[rtl/mi3_cof.sv]
// ----------------------------------------------------------------------------
// mi3_cof
// Two-stage cofactor unit: eighteen products, then nine differences.
// ----------------------------------------------------------------------------
module mi3_cof
   import mi3_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  req_type  in_data,
   output logic     out_valid,
   output cof_type  cof [9],
   output word_type row0 [3]
);

   word_type                   m [9];
   logic signed [PROD_W-1:0]   prod_ff [18];
   word_type                   row0_a_ff [3];
   word_type                   row0_b_ff [3];
   cof_type                    cof_ff [9];
   logic                       vld_a_ff;
   logic                       vld_b_ff;

   assign m[0] = in_data.a00;
   assign m[1] = in_data.a01;
   assign m[2] = in_data.a02;
   assign m[3] = in_data.a10;
   assign m[4] = in_data.a11;
   assign m[5] = in_data.a12;
   assign m[6] = in_data.a20;
   assign m[7] = in_data.a21;
   assign m[8] = in_data.a22;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else begin
         vld_a_ff <= in_valid;
         vld_b_ff <= vld_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 9; k++) begin
         prod_ff[2*k]   <= PROD_W'(m[COF_SEL[k][0]]) * PROD_W'(m[COF_SEL[k][1]]);
         prod_ff[2*k+1] <= PROD_W'(m[COF_SEL[k][2]]) * PROD_W'(m[COF_SEL[k][3]]);
         cof_ff[k]      <= COF_W'(prod_ff[2*k]) - COF_W'(prod_ff[2*k+1]);
      end
      for (int k = 0; k < 3; k++) begin
         row0_a_ff[k] <= m[k];
         row0_b_ff[k] <= row0_a_ff[k];
      end
   end

   assign out_valid = vld_b_ff;
   assign cof       = cof_ff;
   assign row0      = row0_b_ff;

endmodule

[rtl/mi3_det.sv]
// ----------------------------------------------------------------------------
// mi3_det
// Determinant by expansion along row 0, split into partial products,
// followed by sign and magnitude. Cofactors travel alongside.
// ----------------------------------------------------------------------------
module mi3_det
   import mi3_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  cof_type  cof_in [9],
   input  word_type row0 [3],
   output logic     out_valid,
   output cof_type  cof_out [9],
   output det_type  det
);

   localparam int NSTG = 4;

   logic signed [WORD_BITS:0]   lo_s [3];
   logic signed [WORD_BITS:0]   hi_s [3];
   logic signed [PART_W-1:0]    pl_c [3];
   logic signed [PART_W-1:0]    ph_c [3];
   logic signed [PART_W-1:0]    pl_ff [3];
   logic signed [PART_W-1:0]    ph_ff [3];
   logic signed [TERM_W-1:0]    term_ff [3];
   logic signed [DET_W-1:0]     det_ff;
   det_type                     info_ff;
   cof_type                     cof_pipe_ff [NSTG][9];
   logic [NSTG-1:0]             vld_ff;

   // Each cofactor is cut into an unsigned low word and a signed high part.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lo_s[k] = $signed({1'b0, cof_in[k][WORD_BITS-1:0]});
         hi_s[k] = $signed(cof_in[k][COF_W-1:WORD_BITS]);
         pl_c[k] = row0[k] * lo_s[k];
         ph_c[k] = row0[k] * hi_s[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[NSTG-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         pl_ff[k]   <= pl_c[k];
         ph_ff[k]   <= ph_c[k];
         term_ff[k] <= (TERM_W'(ph_ff[k]) <<< WORD_BITS) + TERM_W'(pl_ff[k]);
      end
      det_ff <= DET_W'(term_ff[0]) + DET_W'(term_ff[1]) + DET_W'(term_ff[2]);
      info_ff.zero <= (det_ff == '0);
      info_ff.neg  <= det_ff[DET_W-1];
      info_ff.mag  <= det_ff[DET_W-1] ? DET_W'(-det_ff) : DET_W'(det_ff);
      cof_pipe_ff[0] <= cof_in;
      for (int s = 1; s < NSTG; s++) begin
         cof_pipe_ff[s] <= cof_pipe_ff[s-1];
      end
   end

   assign out_valid = vld_ff[NSTG-1];
   assign cof_out   = cof_pipe_ff[NSTG-1];
   assign det       = info_ff;

endmodule

[rtl/mi3_div.sv]
// ----------------------------------------------------------------------------
// mi3_div
// One result lane: pipelined restoring division of a scaled cofactor by the
// determinant magnitude, one quotient bit a stage, then sign and clipping.
// ----------------------------------------------------------------------------
module mi3_div
   import mi3_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  cof_type  cof_in,
   input  det_type  det_in,
   output logic     out_valid,
   output word_type quo,
   output logic     sat,
   output logic     zero
);

   localparam int NQ = WORD_BITS;

   logic [COF_W-1:0]     cmag;
   logic [REM_W-1:0]     num;
   logic [REM_W-1:0]     rem_ff  [NQ+1];
   logic [DET_W-1:0]     mag_ff  [NQ+1];
   logic [WORD_BITS-1:0] q_ff    [NQ+1];
   logic                 ovf_ff  [NQ+1];
   logic                 neg_ff  [NQ+1];
   logic                 zero_ff [NQ+1];
   logic [NQ:0]          vld_ff;
   logic [WORD_BITS-1:0] q_fin;
   logic                 sat_in;
   word_type             quo_in;
   word_type             quo_ff;
   logic                 sat_ff;
   logic                 zero_out_ff;
   logic                 vld_out_ff;

   assign cmag = cof_in[COF_W-1] ? COF_W'(-cof_in) : COF_W'(cof_in);
   assign num  = REM_W'(cmag) << (2 * FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
   end

   // A quotient that needs more than a word of bits is flagged here; the bit stages
   // below are exact only for a remainder below the divisor times 2^W.
   always_ff @(posedge clock) begin
      rem_ff[0]  <= num;
      mag_ff[0]  <= det_in.mag;
      q_ff[0]    <= '0;
      ovf_ff[0]  <= num >= {det_in.mag, {WORD_BITS{1'b0}}};
      neg_ff[0]  <= cof_in[COF_W-1] ^ det_in.neg;
      zero_ff[0] <= det_in.zero;
   end

   for (genvar s = 1; s <= NQ; s++) begin : g_bit
      localparam int J = NQ - s;
      logic [REM_W:0] diff;

      assign diff = {1'b0, rem_ff[s-1]} - {1'b0, REM_W'(mag_ff[s-1]) << J};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s]  <= diff[REM_W] ? rem_ff[s-1] : diff[REM_W-1:0];
         q_ff[s]    <= diff[REM_W] ? q_ff[s-1]
                                   : (q_ff[s-1] | (WORD_BITS'(1) << J));
         mag_ff[s]  <= mag_ff[s-1];
         ovf_ff[s]  <= ovf_ff[s-1];
         neg_ff[s]  <= neg_ff[s-1];
         zero_ff[s] <= zero_ff[s-1];
      end
   end

   // Positive results clip at 2^(W-1)-1; negative ones may reach -2^(W-1).
   always_comb begin
      q_fin  = q_ff[NQ];
      sat_in = 1'b0;
      quo_in = '0;
      if (!zero_ff[NQ]) begin
         if (neg_ff[NQ]) begin
            sat_in = ovf_ff[NQ] | (q_fin[WORD_BITS-1] & (|q_fin[WORD_BITS-2:0]));
            quo_in = sat_in ? $signed({1'b1, {(WORD_BITS-1){1'b0}}})
                            : $signed(-q_fin);
         end else begin
            sat_in = ovf_ff[NQ] | q_fin[WORD_BITS-1];
            quo_in = sat_in ? $signed({1'b0, {(WORD_BITS-1){1'b1}}})
                            : $signed(q_fin);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_out_ff <= 1'b0;
      end else begin
         vld_out_ff <= vld_ff[NQ];
      end
   end

   always_ff @(posedge clock) begin
      quo_ff      <= quo_in;
      sat_ff      <= sat_in;
      zero_out_ff <= zero_ff[NQ];
   end

   assign out_valid = vld_out_ff;
   assign quo       = quo_ff;
   assign sat       = sat_ff;
   assign zero      = zero_out_ff;

endmodule

[tb/matrix_inverse_3x3_test.sv]
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_test
// Self-checking bench for the 3x3 fixed-point inverse: it drives matrices
// through the start/busy port and checks each result word against a predictor.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_test;
   import mi3_pkg::*;

   localparam int FRAC = FRAC_BITS_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = WORD_BITS + 16;

   typedef logic signed [191:0] wide_type;
   typedef logic [191:0] mag_type;

   class inverse_scoreboard;
      rsp_type pending_inverses[$];
      int mismatches;

      function new();
         mismatches = 0;
      endfunction

      // Computes the expected inverse of one matrix exactly in wide integers.
      function rsp_type predict_inverse(req_type m);
         wide_type a[3][3];
         wide_type cof[3][3];
         wide_type det;
         mag_type mag_det, num, quo;
         mag_type lim;
         word_type res[9];
         logic neg, sat;
         rsp_type r;
         a[0][0] = m.a00; a[0][1] = m.a01; a[0][2] = m.a02;
         a[1][0] = m.a10; a[1][1] = m.a11; a[1][2] = m.a12;
         a[2][0] = m.a20; a[2][1] = m.a21; a[2][2] = m.a22;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               cof[i][j] = a[(i+1)%3][(j+1)%3] * a[(i+2)%3][(j+2)%3]
                         - a[(i+1)%3][(j+2)%3] * a[(i+2)%3][(j+1)%3];
         det = a[0][0]*cof[0][0] + a[0][1]*cof[0][1] + a[0][2]*cof[0][2];
         r = '0;
         if (det == 0) begin
            r.singular = 1'b1;
            return r;
         end
         mag_det = (det < 0) ? mag_type'(-det) : mag_type'(det);
         lim = mag_type'(1) << (WORD_BITS - 1);
         sat = 1'b0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               // The inverse takes the transposed cofactor.
               neg = (cof[j][i] < 0) != (det < 0);
               num = ((cof[j][i] < 0) ? mag_type'(-cof[j][i]) : mag_type'(cof[j][i]))
                     << (2 * FRAC);
               quo = num / mag_det;
               if (!neg && quo >= lim) begin
                  quo = lim - 1;
                  sat = 1'b1;
               end else if (neg && quo > lim) begin
                  quo = lim;
                  sat = 1'b1;
               end
               if (neg)
                  quo = -quo;
               res[3*i+j] = quo[WORD_BITS-1:0];
            end
         end
         r.r00 = res[0]; r.r01 = res[1]; r.r02 = res[2];
         r.r10 = res[3]; r.r11 = res[4]; r.r12 = res[5];
         r.r20 = res[6]; r.r21 = res[7]; r.r22 = res[8];
         r.saturated = sat;
         return r;
      endfunction

      function void note_matrix(req_type m);
         pending_inverses.push_back(predict_inverse(m));
      endfunction

      function void check_inverse(rsp_type got);
         rsp_type want;
         word_type w[9], g[9];
         logic bad;
         if (pending_inverses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result word %h", got);
            return;
         end
         want = pending_inverses.pop_front();
         w = '{want.r00, want.r01, want.r02, want.r10, want.r11, want.r12,
               want.r20, want.r21, want.r22};
         g = '{got.r00, got.r01, got.r02, got.r10, got.r11, got.r12,
               got.r20, got.r21, got.r22};
         bad = (want.singular !== got.singular) || (want.saturated !== got.saturated);
         for (int k = 0; k < 9; k++)
            if (w[k] !== g[k])
               bad = 1'b1;
         if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: inverse mismatch");
               for (int k = 0; k < 9; k++)
                  if (w[k] !== g[k])
                     $display("  r%0d%0d expected %h got %h", k/3, k%3, w[k], g[k]);
               $display("  singular expected %b got %b, saturated expected %b got %b",
                        want.singular, got.singular, want.saturated, got.saturated);
            end
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   inverse_scoreboard sb = new();
   int cycle_count = 0;

   matrix_inverse_3x3 u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid)
         sb.check_inverse(rsp_data);
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Offers one word, with random idle cycles first, and returns at the edge
   // that accepts it. Start is left high so back-to-back words need no toggle.
   task automatic send_matrix(req_type m, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= m;
      do
         @(posedge clock);
      while (busy);
      sb.note_matrix(m);
   endtask

   function automatic word_type rand_element(int kind);
      case (kind)
         0: return word_type'($urandom);
         1: return word_type'($signed($urandom_range(8)) - 4) <<< FRAC;
         2: return word_type'($signed($urandom_range(2047)) - 1024) <<< ($urandom_range(20));
         3: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         default: return word_type'($signed($urandom_range(6)) - 3);
      endcase
   endfunction

   function automatic req_type rand_matrix();
      req_type m;
      int kind;
      int shape;
      kind = $urandom_range(4);
      m.a00 = rand_element(kind); m.a01 = rand_element(kind); m.a02 = rand_element(kind);
      m.a10 = rand_element(kind); m.a11 = rand_element(kind); m.a12 = rand_element(kind);
      m.a20 = rand_element(kind); m.a21 = rand_element(kind); m.a22 = rand_element(kind);
      shape = $urandom_range(9);
      // A share of matrices is made singular or diagonal on purpose.
      if (shape == 0) begin
         m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
      end else if (shape == 1) begin
         m.a01 = m.a00; m.a11 = m.a10; m.a21 = m.a20;
      end else if (shape == 2) begin
         m.a01 = '0; m.a02 = '0; m.a10 = '0; m.a12 = '0; m.a20 = '0; m.a21 = '0;
      end
      return m;
   endfunction

   function automatic req_type diag_matrix(word_type d0, word_type d1, word_type d2);
      req_type m;
      m = '0;
      m.a00 = d0; m.a11 = d1; m.a22 = d2;
      return m;
   endfunction

   initial begin
      req_type m;
      word_type one;
      one = word_type'(1) <<< FRAC;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_matrix(diag_matrix(one, one, one), 0);
      send_matrix('0, 0);
      send_matrix(diag_matrix(-one, one, -one), 0);
      send_matrix(diag_matrix(one <<< 1, one <<< 2, one >>> 1), 0);
      send_matrix(diag_matrix(32'sd1, one, one), 0);
      send_matrix(diag_matrix(-32'sd1, one, one), 0);
      send_matrix(diag_matrix(32'sh80000000, 32'sh80000000, 32'sh80000000), 0);
      send_matrix(diag_matrix(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff), 0);
      send_matrix(diag_matrix(32'sh80000000, 32'sh7fffffff, 32'sh80000000), 0);
      send_matrix('{default: 32'sh7fffffff}, 0);
      send_matrix('{default: 32'sh80000000}, 0);
      send_matrix('{default: 32'shffffffff}, 0);
      m = '0;
      m.a01 = one; m.a12 = one; m.a20 = one;
      send_matrix(m, 0);
      m = '{one, one <<< 1, one * 3, 0, one, one <<< 2, one * 5, one * 6, 0};
      send_matrix(m, 0);
      m = '{one, one <<< 1, one * 3, one <<< 1, one <<< 2, one * 6, one, 0, one};
      send_matrix(m, 0);
      m = '{32'sh55555555, 32'shaaaaaaaa, 32'sh0000ffff, 32'shffff0000, 32'sh12345678,
            32'shedcba987, 32'sh00000001, 32'sh7fffffff, 32'sh80000001};
      send_matrix(m, 0);
      send_matrix(diag_matrix(one * 4, -one * 4, 32'sh40000000), 0);

      // Hold off until the pipeline has fully drained once.
      start <= 1'b0;
      while (sb.pending_inverses.size() != 0)
         @(posedge clock);

      repeat (583) send_matrix(rand_matrix(), 31);
      repeat (583) send_matrix(rand_matrix(), 51);
      repeat (584) send_matrix(rand_matrix(), 0);
      start <= 1'b0;

      while (sb.pending_inverses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
